// ----- hdl/splitmix_matrix_fill_fp64_macros.svh -----
// Assertion macros shared by the matrix fill generator.
`ifndef SPLITMIX_MATRIX_FILL_FP64_MACROS_SVH
`define SPLITMIX_MATRIX_FILL_FP64_MACROS_SVH

// Same-cycle implication, clocked on clk_i, quiet during reset.
`define SMF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, quiet during reset.
`define SMF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/smf_pkg.sv -----
// Package: types and constants of the matrix fill generator.
`default_nettype none

package smf_pkg;

  localparam int unsigned MAX_COLUMNS = 1048576;

  localparam logic [63:0] GOLDEN = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_A  = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_B  = 64'h94d049bb133111eb;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_SEED       = 2'd0,
    CFG_START_ROW  = 2'd1,
    CFG_ROW_COUNT  = 2'd2,
    CFG_ROW_LENGTH = 2'd3
  } cfg_idx_e;

  // Item passed from front to back
  typedef struct packed {
    logic [63:0] gen_state;
    logic [31:0] row;
    logic [19:0] col;
    logic        last_row;
    logic        last_block;
  } smf_item_t;

endpackage

`default_nettype wire

// ----- hdl/smf_front.sv -----
// Front: configuration registers, row offset multiplier, stream position.
`default_nettype none

module smf_front #(
  parameter int unsigned MaxColumns = 1048576
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [63:0]      cfg_data_i,
  input  logic             accept_i,
  input  logic             restart_i,
  output logic             busy_o,
  output smf_pkg::smf_item_t item_o
);
  import smf_pkg::*;

  localparam logic [20:0] MaxLen = 21'(MaxColumns);

  logic [63:0] seed_q;
  logic [31:0] start_row_q, row_count_q;
  logic [20:0] row_length_q;

  // serial (start_row + 1) * GOLDEN
  logic [63:0] block_off_q, mcand_q;
  logic [32:0] mult_q;
  logic [5:0]  cnt_q;
  logic        busy_q;

  logic [63:0] gen_q, off_q;
  logic [31:0] row_q;
  logic [19:0] col_q;
  logic        started_q;

  logic        restart_eff, end_row, end_block;
  logic [31:0] cur_row, place, cnt;
  logic [19:0] cur_col;
  logic [63:0] cur_off, base, gen_d;
  logic [20:0] len;
  logic        cfg_wr;

  assign cfg_ready_o = ~busy_q;
  assign busy_o      = busy_q;
  assign cfg_wr      = cfg_valid_i & cfg_ready_o;

  // Position and state of the current item
  always_comb begin
    restart_eff = restart_i | ~started_q;
    cur_row = restart_eff ? start_row_q : row_q;
    cur_col = restart_eff ? 20'd0 : col_q;
    cur_off = restart_eff ? block_off_q : off_q;
    base    = (cur_col == 20'd0) ? seed_q + cur_off : gen_q;
    gen_d   = base + GOLDEN;
    if (row_length_q == 21'd0) begin
      len = 21'd1;
    end else if (row_length_q > MaxLen) begin
      len = MaxLen;
    end else begin
      len = row_length_q;
    end
    cnt       = (row_count_q == 32'd0) ? 32'd1 : row_count_q;
    end_row   = ({1'b0, cur_col} + 21'd1) >= len;
    place     = cur_row - start_row_q;
    end_block = end_row && (place >= cnt - 32'd1);
    item_o.gen_state  = gen_d;
    item_o.row        = cur_row;
    item_o.col        = cur_col;
    item_o.last_row   = end_row;
    item_o.last_block = end_block;
  end

  // Config registers and offset multiplier
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q       <= '0;
      start_row_q  <= '0;
      row_count_q  <= 32'd1;
      row_length_q <= 21'd1;
      block_off_q  <= GOLDEN;
      mcand_q      <= '0;
      mult_q       <= '0;
      cnt_q        <= '0;
      busy_q       <= 1'b0;
    end else if (busy_q) begin
      if (mult_q[0]) begin
        block_off_q <= block_off_q + mcand_q;
      end
      mcand_q <= mcand_q << 1;
      mult_q  <= mult_q >> 1;
      cnt_q   <= cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_q <= 1'b0;
      end
    end else if (cfg_wr) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SEED:       seed_q <= cfg_data_i;
        CFG_START_ROW: begin
          start_row_q <= cfg_data_i[31:0];
          block_off_q <= '0;
          mcand_q     <= GOLDEN;
          mult_q      <= {1'b0, cfg_data_i[31:0]} + 33'd1;
          cnt_q       <= 6'd33;
          busy_q      <= 1'b1;
        end
        CFG_ROW_COUNT:  row_count_q <= cfg_data_i[31:0];
        CFG_ROW_LENGTH: row_length_q <= cfg_data_i[20:0];
        default: ;
      endcase
    end
  end

  // Stream position update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q     <= '0;
      off_q     <= '0;
      row_q     <= '0;
      col_q     <= '0;
      started_q <= 1'b0;
    end else if (accept_i) begin
      started_q <= 1'b1;
      gen_q     <= gen_d;
      if (end_block) begin
        row_q <= start_row_q;
        col_q <= '0;
        off_q <= block_off_q;
      end else if (end_row) begin
        row_q <= cur_row + 32'd1;
        col_q <= '0;
        off_q <= cur_off + GOLDEN;
      end else begin
        row_q <= cur_row;
        off_q <= cur_off;
        col_q <= cur_col + 20'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/smf_fifo.sv -----
// Two-entry queue between front and back.
`default_nettype none

module smf_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_i,
  input  smf_pkg::smf_item_t wdata_i,
  output logic               full_o,
  input  logic               rd_i,
  output smf_pkg::smf_item_t rdata_o,
  output logic               empty_o
);
  import smf_pkg::*;

  smf_item_t  mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= '0;
    end else begin
      if (wr_i) wptr_q <= ~wptr_q;
      if (rd_i) rptr_q <= ~rptr_q;
      if (wr_i && !rd_i) begin
        count_q <= count_q + 2'd1;
      end else if (rd_i && !wr_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/smf_back.sv -----
// Back: splitmix64 mix, conversion to binary64, result register.
`default_nettype none

module smf_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  smf_pkg::smf_item_t q_item_i,
  output logic               q_rd_o,
  input  logic               pop,
  output logic               empty,
  output logic [63:0]        value_bits_o,
  output logic [31:0]        row_index_o,
  output logic [19:0]        column_index_o,
  output logic               last_in_row_o,
  output logic               last_in_block_o
);
  import smf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL1, ST_SUM1, ST_MUL2, ST_SUM2, ST_CONV, ST_NORM, ST_DONE
  } state_e;

  state_e      state_q;
  smf_item_t   meta_q;
  logic [63:0] z_q;
  logic [63:0] p0_q;
  logic [31:0] p1_q, p2_q;
  logic        sign_q, zero_q;
  logic [52:0] mag_q;
  logic [5:0]  lz_q;
  logic [2:0]  step_q;
  logic        out_valid_q;

  logic [63:0] k, y, bits;
  logic [52:0] m;
  logic [52:0] mag_sh;
  logic [5:0]  sh;
  logic        top_zero;
  logic [10:0] expo;

  assign empty  = ~out_valid_q;
  assign q_rd_o = (state_q == ST_IDLE) && !q_empty_i;

  // Partial-product sum, shift search step and packing
  always_comb begin
    k = (state_q == ST_MUL1) ? MIX_A : MIX_B;
    y = p0_q + {p1_q + p2_q, 32'd0};
    m = z_q[63:11];
    case (step_q)
      3'd0:    sh = 6'd32;
      3'd1:    sh = 6'd16;
      3'd2:    sh = 6'd8;
      3'd3:    sh = 6'd4;
      3'd4:    sh = 6'd2;
      default: sh = 6'd1;
    endcase
    top_zero = (mag_q >> (6'd53 - sh)) == 53'd0;
    mag_sh   = mag_q << sh;
    expo     = 11'd1022 - {5'd0, lz_q};
    bits     = zero_q ? 64'd0 : {sign_q, expo, mag_q[51:0]};
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        meta_q <= q_item_i;
        z_q    <= q_item_i.gen_state ^ (q_item_i.gen_state >> 30);
      end
      ST_MUL1, ST_MUL2: begin
        p0_q <= z_q[31:0] * k[31:0];
        p1_q <= 32'(z_q[31:0] * k[63:32]);
        p2_q <= 32'(z_q[63:32] * k[31:0]);
      end
      ST_SUM1: z_q <= y ^ (y >> 27);
      ST_SUM2: z_q <= y ^ (y >> 31);
      ST_CONV: begin
        sign_q <= ~m[52];
        zero_q <= (m == 53'h10000000000000);
        mag_q  <= m[52] ? {1'b0, m[51:0]} : 53'h10000000000000 - m;
        lz_q   <= '0;
        step_q <= '0;
      end
      ST_NORM: begin
        step_q <= step_q + 3'd1;
        if (top_zero) begin
          mag_q <= mag_sh;
          lz_q  <= lz_q + sh;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || pop) begin
          value_bits_o    <= bits;
          row_index_o     <= meta_q.row;
          column_index_o  <= meta_q.col;
          last_in_row_o   <= meta_q.last_row;
          last_in_block_o <= meta_q.last_block;
        end
      end
      default: ;
    endcase
  end

  // Sequencer and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == ST_DONE && (!out_valid_q || pop)) begin
        out_valid_q <= 1'b1;
      end else if (pop && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: if (!q_empty_i) state_q <= ST_MUL1;
        ST_MUL1: state_q <= ST_SUM1;
        ST_SUM1: state_q <= ST_MUL2;
        ST_MUL2: state_q <= ST_SUM2;
        ST_SUM2: state_q <= ST_CONV;
        ST_CONV: state_q <= ST_NORM;
        ST_NORM: if (step_q == 3'd5) state_q <= ST_DONE;
        ST_DONE: begin
          if (!out_valid_q || pop) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hdl/splitmix_matrix_fill_fp64.sv -----
// Top level: pseudo-random FP64 matrix element streamer.
//
//  channel  handshake               payload
//  input    push / full             restart_i
//  result   empty / pop             value_bits_o, row_index_o, column_index_o,
//                                   last_in_row_o, last_in_block_o
//  config   cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// The back sequencer takes one item at a time from the queue, only when idle
// (two 64-bit multiplies as three 32x32 partial products each, then a
// six-step normalize). The front positions an item in the cycle it is pushed.
// A start_row write starts a serial multiply; full and cfg_ready_o hold off
// until it ends. Reset is asynchronous, active low, and needs no pass.
`default_nettype none
`include "splitmix_matrix_fill_fp64_macros.svh"

module splitmix_matrix_fill_fp64 #(
  parameter int unsigned MaxColumns = smf_pkg::MAX_COLUMNS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        restart_i,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] value_bits_o,
  output logic [31:0] row_index_o,
  output logic [19:0] column_index_o,
  output logic        last_in_row_o,
  output logic        last_in_block_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);
  import smf_pkg::*;

  smf_item_t f_item, q_item;
  logic      f_busy, q_full, q_empty, q_rd, accept;

  assign full   = q_full | f_busy;
  assign accept = push & ~full;

  smf_front #(.MaxColumns(MaxColumns)) u_front (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .accept_i(accept), .restart_i, .busy_o(f_busy), .item_o(f_item)
  );

  smf_fifo u_fifo (
    .clk_i, .rst_ni, .wr_i(accept), .wdata_i(f_item), .full_o(q_full),
    .rd_i(q_rd), .rdata_o(q_item), .empty_o(q_empty)
  );

  smf_back u_back (
    .clk_i, .rst_ni, .q_empty_i(q_empty), .q_item_i(q_item), .q_rd_o(q_rd),
    .pop, .empty, .value_bits_o, .row_index_o, .column_index_o,
    .last_in_row_o, .last_in_block_o
  );

  `SMF_ASSERT_NOW(a_block_ends_row, !empty && last_in_block_o, last_in_row_o, "block end without row end")
  `SMF_ASSERT_NOW(a_mul_blocks_push, !cfg_ready_o, full, "item taken during offset multiply")
  `SMF_ASSERT_NOW(a_max_col_ends_row, !empty && column_index_o == 20'hfffff, last_in_row_o, "last column did not end row")

endmodule

`default_nettype wire
